>>> hdl/drbc_pkg.sv
// shared constants and types for the dram row buffer controller
`timescale 1ns / 1ps
`default_nettype none

package drbc_pkg;

  localparam int ADDR_W = 14;
  localparam int DATA_W = 32;
  localparam int LAT_W = 12;
  localparam int KIND_W = 3;
  localparam int OP_W = 2;
  localparam int DELAY_W = 10;
  localparam int CFG_W = 14;
  localparam int CFG_IDX_W = 2;
  localparam int WORD_W = ADDR_W - 2;
  localparam int MAX_WORDS = 1 << WORD_W;

  localparam int ROW_WORDS_DEF = 256;
  localparam int ROW_COUNT_DEF = 16;

  localparam logic [OP_W-1:0] OP_READ = 2'd0;
  localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
  localparam logic [OP_W-1:0] OP_FLUSH = 2'd2;

  localparam logic [KIND_W-1:0] KIND_FIRST = 3'd0;
  localparam logic [KIND_W-1:0] KIND_HIT = 3'd1;
  localparam logic [KIND_W-1:0] KIND_CONFLICT = 3'd2;
  localparam logic [KIND_W-1:0] KIND_ERROR = 3'd3;
  localparam logic [KIND_W-1:0] KIND_FLUSH = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_ROW_DELAY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COL_DELAY = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DATA_START = 2'd2;

  localparam logic [DELAY_W-1:0] ROW_DELAY_RST = 10'd10;
  localparam logic [DELAY_W-1:0] COL_DELAY_RST = 10'd2;
  localparam logic [ADDR_W-1:0] DATA_START_RST = 14'd0;

  typedef struct packed {
    logic is_read;
    logic [LAT_W-1:0] latency;
    logic [KIND_W-1:0] kind;
    logic [DATA_W-1:0] count;
  } stage_t;

endpackage

`default_nettype wire

>>> hdl/drbc_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module drbc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  wire logic                                    clk,
  input  wire logic                                    wr_en,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                        wr_data,
  input  wire logic                                    rd_en,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                             rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> hdl/dram_row_buffer_controller.sv
// an accepted request passes through the s1 stage register and then the output registers
// throughput: one request per cycle while results are taken, single ram port pair
// the row compare and the counter update are done in the accept cycle
// reset: synchronous; the word store is then zeroed one word per cycle,
// all min(ROW_WORDS*ROW_COUNT, 4096) words, with no request accepted meanwhile
`timescale 1ns / 1ps
`default_nettype none

module dram_row_buffer_controller
  import drbc_pkg::*;
#(
  parameter int ROW_WORDS = ROW_WORDS_DEF,
  parameter int ROW_COUNT = ROW_COUNT_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     cfg_write,
  input  wire logic [CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [CFG_W-1:0]         cfg_data,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic [OP_W-1:0]          opcode,
  input  wire logic [ADDR_W-1:0]        byte_address,
  input  wire logic signed [DATA_W-1:0] write_data,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic signed [DATA_W-1:0]      read_data,
  output logic [LAT_W-1:0]              latency,
  output logic [KIND_W-1:0]             access_kind,
  output logic [DATA_W-1:0]             update_count
);

  localparam int unsigned STORE_WORDS = ROW_WORDS * ROW_COUNT;
  localparam int unsigned STORE_BYTES = STORE_WORDS * 4;
  localparam int MEM_DEPTH = (STORE_WORDS < MAX_WORDS) ? STORE_WORDS : MAX_WORDS;
  localparam int MEM_AW = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int ROW_W = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
  localparam int ROW_SHIFT = WORD_W + $clog2(ROW_WORDS);
  localparam int ROW_RECIP = ((1 << ROW_SHIFT) + ROW_WORDS - 1) / ROW_WORDS;
  localparam int RECIP_W = $clog2(ROW_RECIP + 1);
  localparam int PROD_W = WORD_W + RECIP_W;

  logic [DELAY_W-1:0] row_delay;
  logic [DELAY_W-1:0] col_delay;
  logic [ADDR_W-1:0]  data_start;

  logic               row_open;
  logic [ROW_W-1:0]   open_row;
  logic [DATA_W-1:0]  updates;
  logic [DATA_W-1:0]  updates_next;

  logic               clearing;
  logic [MEM_AW-1:0]  clr_addr;

  logic               s1_valid;
  stage_t             s1;
  stage_t             s1_next;
  logic               s1_move;
  logic               accept;

  logic [WORD_W-1:0]  word;
  logic [PROD_W-1:0]  prod;
  logic [PROD_W-1:0]  quot;
  logic [ROW_W-1:0]   row;
  logic               addr_ok;
  logic               acc_ok;
  logic               activate;
  logic               wr_count;
  logic [DATA_W+1:0]  sum;
  logic [LAT_W-1:0]   rd12;
  logic [LAT_W-1:0]   cd12;

  logic               ram_we;
  logic [MEM_AW-1:0]  ram_waddr;
  logic [DATA_W-1:0]  ram_wdata;
  logic [DATA_W-1:0]  ram_rdata;

  assign s1_move = s1_valid && (!out_valid || out_ready);
  assign in_ready = !clearing && (!s1_valid || s1_move);
  assign accept = in_valid && in_ready;

  always_comb begin
    word = byte_address[ADDR_W-1:2];
    prod = PROD_W'(word) * PROD_W'(ROW_RECIP);
    quot = prod >> ROW_SHIFT;
    row = ROW_W'(quot);
    addr_ok = (byte_address[1:0] == 2'b00) && (byte_address >= data_start) &&
              (32'(byte_address) < STORE_BYTES);
    acc_ok = ((opcode == OP_READ) || (opcode == OP_WRITE)) && addr_ok;
    rd12 = LAT_W'(row_delay);
    cd12 = LAT_W'(col_delay);
    activate = 1'b0;
    s1_next.is_read = acc_ok && (opcode == OP_READ);
    priority if (opcode == OP_FLUSH) begin
      s1_next.kind = KIND_FLUSH;
      s1_next.latency = rd12;
    end else if (acc_ok && !row_open) begin
      s1_next.kind = KIND_FIRST;
      s1_next.latency = rd12 + cd12;
      activate = 1'b1;
    end else if (acc_ok && (open_row == row)) begin
      s1_next.kind = KIND_HIT;
      s1_next.latency = cd12;
    end else if (acc_ok) begin
      s1_next.kind = KIND_CONFLICT;
      s1_next.latency = (rd12 << 1) + cd12;
      activate = 1'b1;
    end else begin
      s1_next.kind = KIND_ERROR;
      s1_next.latency = '0;
    end
    wr_count = acc_ok && (opcode == OP_WRITE);
    sum = (DATA_W+2)'(updates) + (DATA_W+2)'(activate) + (DATA_W+2)'(wr_count);
    updates_next = (sum[DATA_W+1:DATA_W] != 2'b00) ? '1 : sum[DATA_W-1:0];
    s1_next.count = updates_next;
  end

  always_comb begin
    if (clearing) begin
      ram_we = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = '0;
    end else begin
      ram_we = accept && wr_count;
      ram_waddr = word[MEM_AW-1:0];
      ram_wdata = write_data;
    end
  end

  drbc_ram #(
    .WIDTH(DATA_W),
    .DEPTH(MEM_DEPTH)
  ) u_store (
    .clk    (clk),
    .wr_en  (ram_we),
    .wr_addr(ram_waddr),
    .wr_data(ram_wdata),
    .rd_en  (accept),
    .rd_addr(word[MEM_AW-1:0]),
    .rd_data(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      row_delay <= ROW_DELAY_RST;
      col_delay <= COL_DELAY_RST;
      data_start <= DATA_START_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_ROW_DELAY: row_delay <= cfg_data[DELAY_W-1:0];
        CFG_COL_DELAY: col_delay <= cfg_data[DELAY_W-1:0];
        CFG_DATA_START: data_start <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == MEM_AW'(MEM_DEPTH - 1)) begin
        clearing <= 1'b0;
      end else begin
        clr_addr <= clr_addr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_open <= 1'b0;
      open_row <= '0;
      updates <= '0;
    end else if (accept) begin
      updates <= updates_next;
      if (acc_ok) begin
        row_open <= 1'b1;
        open_row <= row;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
    if (accept) begin
      s1 <= s1_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (s1_move) begin
      read_data <= s1.is_read ? $signed(ram_rdata) : '0;
      latency <= s1.latency;
      access_kind <= s1.kind;
      update_count <= s1.count;
    end
  end

  a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !in_ready)
    else $error("request taken during store clearing");

  a_count_monotonic: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> updates >= $past(updates))
    else $error("update counter went backward");

  a_hit_latency: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (access_kind == KIND_HIT)) |-> (latency == LAT_W'(col_delay)))
    else $error("row hit latency mismatch");

  a_error_quiet: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (access_kind == KIND_ERROR)) |-> ((latency == '0) && (read_data == '0)))
    else $error("address error result not zero");

  a_row_opened: assert property (@(posedge clk) disable iff (rst)
    (accept && acc_ok) |=> row_open)
    else $error("row not open after access");

endmodule

`default_nettype wire

>>> tb/tb.sv
// self-checking testbench for the dram row buffer controller with random traffic and stalls
`timescale 1ns / 1ps

module tb
  import drbc_pkg::*;
;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int STORE_WORDS = ROW_WORDS_DEF * ROW_COUNT_DEF;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] wdata;
  } mem_req_t;

  typedef struct packed {
    logic [DATA_W-1:0] rdata;
    logic [LAT_W-1:0] lat;
    logic [KIND_W-1:0] kind;
    logic [DATA_W-1:0] count;
  } access_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [OP_W-1:0] opcode = '0;
  logic [ADDR_W-1:0] byte_address = '0;
  logic signed [DATA_W-1:0] write_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [DATA_W-1:0] read_data;
  logic [LAT_W-1:0] latency;
  logic [KIND_W-1:0] access_kind;
  logic [DATA_W-1:0] update_count;

  dram_row_buffer_controller dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .opcode(opcode),
    .byte_address(byte_address),
    .write_data(write_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .read_data(read_data),
    .latency(latency),
    .access_kind(access_kind),
    .update_count(update_count)
  );

  always #1 clk = ~clk;

  // expected dram state and timing registers
  logic [DELAY_W-1:0] row_delay_q = ROW_DELAY_RST;
  logic [DELAY_W-1:0] col_delay_q = COL_DELAY_RST;
  logic [ADDR_W-1:0] data_start_q = DATA_START_RST;
  logic [DATA_W-1:0] word_mem [STORE_WORDS];
  logic row_is_open = 1'b0;
  logic [3:0] cur_row = '0;
  logic [DATA_W-1:0] update_total = '0;

  mem_req_t pending_reqs[$];
  access_result_t expected_results[$];
  logic [ADDR_W-1:0] written_addrs[$];
  int last_row = 0;
  int error_count = 0;
  int result_idx = 0;
  int idle_cycles = 0;
  int burst_left = 0;
  int gap_left = 0;
  int stall_cnt = 0;
  int stall_mode = 0;
  mem_req_t next_req;
  access_result_t want;

  initial begin
    for (int i = 0; i < STORE_WORDS; i++) word_mem[i] = '0;
  end

  function automatic void count_update();
    if (update_total != 32'hFFFF_FFFF) update_total++;
  endfunction

  function automatic access_result_t predict_access(input logic [OP_W-1:0] op,
                                                    input logic [ADDR_W-1:0] addr,
                                                    input logic [DATA_W-1:0] wdata);
    access_result_t res;
    int word;
    int row;
    int rd;
    int cd;
    rd = int'(row_delay_q);
    cd = int'(col_delay_q);
    res.rdata = '0;
    res.lat = '0;
    res.kind = KIND_ERROR;
    if (op == OP_FLUSH) begin
      res.lat = LAT_W'(rd);
      res.kind = KIND_FLUSH;
    end else if ((op == OP_READ || op == OP_WRITE) && addr[1:0] == 2'b00 &&
                 addr >= data_start_q && int'(addr) < 4 * STORE_WORDS) begin
      word = int'(addr[ADDR_W-1:2]);
      row = word / ROW_WORDS_DEF;
      if (!row_is_open) begin
        res.kind = KIND_FIRST;
        res.lat = LAT_W'(rd + cd);
        count_update();
      end else if (cur_row == row) begin
        res.kind = KIND_HIT;
        res.lat = LAT_W'(cd);
      end else begin
        res.kind = KIND_CONFLICT;
        res.lat = LAT_W'(2 * rd + cd);
        count_update();
      end
      row_is_open = 1'b1;
      cur_row = 4'(row);
      if (op == OP_READ) begin
        res.rdata = word_mem[word];
      end else begin
        word_mem[word] = wdata;
        count_update();
      end
    end
    res.count = update_total;
    return res;
  endfunction

  function automatic mem_req_t random_request();
    mem_req_t r;
    int pick;
    int col;
    pick = $urandom_range(0, 99);
    r.op = (pick < 45) ? OP_READ : (pick < 85) ? OP_WRITE : (pick < 93) ? OP_FLUSH : OP_UNUSED;
    case ($urandom_range(0, 9))
      0: r.wdata = '0;
      1: r.wdata = 32'hFFFF_FFFF;
      2: r.wdata = 32'h8000_0000;
      default: r.wdata = $urandom();
    endcase
    if (r.op == OP_READ && written_addrs.size() != 0 && $urandom_range(0, 1) == 1) begin
      r.addr = written_addrs[$urandom_range(0, written_addrs.size() - 1)];
    end else begin
      if ($urandom_range(0, 2) == 0) last_row = $urandom_range(0, ROW_COUNT_DEF - 1);
      col = $urandom_range(0, ROW_WORDS_DEF - 1);
      r.addr = ADDR_W'((last_row * ROW_WORDS_DEF + col) * 4);
      if ($urandom_range(0, 15) == 0) r.addr[1:0] = 2'($urandom_range(1, 3));
    end
    if (r.op == OP_WRITE) begin
      written_addrs.push_back(r.addr);
      if (written_addrs.size() > 32) void'(written_addrs.pop_front());
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] want_v,
                                 input logic [31:0] got_v);
    $display("result %0d: %s expected %h got %h", result_idx, what, want_v, got_v);
    error_count++;
  endtask

  task automatic push_req(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] addr,
                          input logic [DATA_W-1:0] wdata);
    mem_req_t r;
    r.op = op;
    r.addr = addr;
    r.wdata = wdata;
    pending_reqs.push_back(r);
  endtask

  task automatic wait_idle();
    while (pending_reqs.size() != 0 || in_valid || expected_results.size() != 0 || !in_ready)
      @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      CFG_ROW_DELAY: row_delay_q = value[DELAY_W-1:0];
      CFG_COL_DELAY: col_delay_q = value[DELAY_W-1:0];
      CFG_DATA_START: data_start_q = value;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic program_timing(input int rd, input int cd, input int ds);
    wait_idle();
    write_register(CFG_ROW_DELAY, CFG_W'(rd));
    write_register(CFG_COL_DELAY, CFG_W'(cd));
    write_register(CFG_DATA_START, CFG_W'(ds));
  endtask

  task automatic run_phase(input int rd, input int cd, input int ds, input int n);
    program_timing(rd, cd, ds);
    for (int i = 0; i < n; i++) pending_reqs.push_back(random_request());
  endtask

  // request driver: bursts with random gaps
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready)
        expected_results.push_back(predict_access(opcode, byte_address, write_data));
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          next_req = pending_reqs.pop_front();
          in_valid <= 1'b1;
          opcode <= next_req.op;
          byte_address <= next_req.addr;
          write_data <= next_req.wdata;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result side backpressure
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      stall_cnt++;
      if (stall_cnt % 128 == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 1) == 1);
        2: out_ready <= (stall_cnt % 8 != 0);
        default: out_ready <= (stall_cnt % 16 < 3);
      endcase
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", '0, '0);
      end else begin
        want = expected_results.pop_front();
        if (read_data !== want.rdata) report_mismatch("read_data", want.rdata, read_data);
        if (latency !== want.lat) report_mismatch("latency", 32'(want.lat), 32'(latency));
        if (access_kind !== want.kind)
          report_mismatch("access_kind", 32'(want.kind), 32'(access_kind));
        if (update_count !== want.count)
          report_mismatch("update_count", want.count, update_count);
      end
      result_idx++;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    program_timing(10, 2, 64);
    push_req(OP_FLUSH, 14'h1234, 32'h1357_9BDF);
    push_req(OP_READ, 14'h0040, '0);
    push_req(OP_WRITE, 14'h0040, 32'h7FFF_FFFF);
    push_req(OP_READ, 14'h0040, '0);
    push_req(OP_WRITE, 14'h3FFC, 32'h8000_0000);
    push_req(OP_READ, 14'h3FFC, '0);
    push_req(OP_READ, 14'h3FFD, '0);
    push_req(OP_WRITE, 14'h3FFE, 32'h1234_5678);
    push_req(OP_READ, 14'h3FFF, '0);
    push_req(OP_READ, 14'h003C, '0);
    push_req(OP_WRITE, 14'h0000, 32'hFFFF_FFFF);
    push_req(OP_UNUSED, 14'h0040, 32'hFFFF_FFFF);
    push_req(OP_FLUSH, 14'h3FFF, 32'hFFFF_FFFF);
    push_req(OP_WRITE, 14'h0044, 32'hFFFF_FFFF);
    push_req(OP_READ, 14'h0044, '0);
    push_req(OP_READ, 14'h0400, '0);
    push_req(OP_WRITE, 14'h2000, 32'h5555_5555);
    push_req(OP_WRITE, 14'h1FFC, 32'hAAAA_AAAA);
    push_req(OP_READ, 14'h2000, '0);
    push_req(OP_READ, 14'h1FFC, '0);
    push_req(OP_READ, 14'h0040, '0);

    run_phase(1023, 1023, 0, 100);
    run_phase(0, 0, 0, 100);
    run_phase($urandom_range(0, 1023), $urandom_range(0, 1023), $urandom_range(0, 4096), 100);
    run_phase($urandom_range(0, 1023), $urandom_range(0, 1023), $urandom_range(0, 4096), 100);
    run_phase(5, 3, 16383, 30);
    run_phase($urandom_range(0, 1023), $urandom_range(0, 1023), 0, 100);

    wait_idle();
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
